// ----- sv/assert_macros.svh -----
// assertion macros used by polynomial_term_accumulate_evaluate
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PTE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pte assertion failed");

// next-cycle implication
`define PTE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pte assertion failed");

`endif

// ----- sv/pte_pkg.sv -----
// types, codes and sizes for the polynomial term store
// no dependencies
`default_nettype none

package pte_pkg;

  localparam int NUM_DEGREES = 16;
  localparam int DEG_W       = (NUM_DEGREES > 1) ? $clog2(NUM_DEGREES) : 1;

  // operation codes
  localparam logic [1:0] FN_ADD   = 2'd0;
  localparam logic [1:0] FN_EVAL  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  // status codes
  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_MERGED    = 3'd1;
  localparam logic [2:0] ST_REJECTED  = 3'd2;
  localparam logic [2:0] ST_EVALUATED = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] coefficient;
    logic [7:0]         degree;
    logic signed [31:0] point;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_t;

  // request from sequencer to coefficient store
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             clr;
    logic [DEG_W-1:0] addr;
    logic [31:0]      wr_data;
  } store_req_t;

  // registered read response
  typedef struct packed {
    logic        hit;
    logic [31:0] data;
  } store_rsp_t;

endpackage

`default_nettype wire

// ----- sv/pte_store.sv -----
// coefficient store: memory with per-entry valid bits, one port
// depends on pte_pkg
`default_nettype none

module pte_store (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pte_pkg::store_req_t req,
  output pte_pkg::store_rsp_t      rsp
);

  logic [31:0]                    mem [pte_pkg::NUM_DEGREES];
  logic [pte_pkg::NUM_DEGREES-1:0] vld_r;
  logic [31:0]                    rd_data_r;
  logic                           rd_hit_r;

  // valid bits: an entry never written since reset or clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
      rd_hit_r  <= vld_r[req.addr];
    end
  end

  assign rsp.hit  = rd_hit_r;
  assign rsp.data = rd_hit_r ? rd_data_r : 32'd0;

endmodule

`default_nettype wire

// ----- sv/polynomial_term_accumulate_evaluate.sv -----
// per item: add reads the store entry, writes it back, then pushes; clear and rejected
// items go straight to the push; evaluate uses one shared multiply-add walking the
// coefficient store one degree per cycle, then a drain state and a push state
// a blocked push waits for the output slot; in_stall holds new items off until idle
// the output register lets the next item in while a result waits
// synchronous active-low reset: store reads as all zero, sequencer idle, no result
`default_nettype none
`include "assert_macros.svh"

module polynomial_term_accumulate_evaluate (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pte_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pte_pkg::out_t      out_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ADD_RD   = 3'd1;
  localparam logic [2:0] S_ADD_WR   = 3'd2;
  localparam logic [2:0] S_EVAL     = 3'd3;
  localparam logic [2:0] S_EVAL_END = 3'd4;
  localparam logic [2:0] S_PUSH     = 3'd5;

  localparam logic [pte_pkg::DEG_W-1:0] TOP_DEG = pte_pkg::DEG_W'(pte_pkg::NUM_DEGREES - 1);

  logic [2:0]                 state_r, state_nxt;
  logic [pte_pkg::DEG_W-1:0]  cnt_r, cnt_nxt;
  logic                       pend_r;
  logic [31:0]                acc_r, acc_nxt;
  logic [31:0]                pt_r, coef_r;
  logic [pte_pkg::DEG_W-1:0]  deg_r;
  logic                       deg0_r;
  pte_pkg::out_t              res_r, res_nxt;
  pte_pkg::out_t              out_r;
  logic                       out_valid_r;

  pte_pkg::store_req_t        req;
  pte_pkg::store_rsp_t        rsp;

  logic                       accept;
  logic                       slot_free;
  logic                       in_range;
  logic [31:0]                mac;

  pte_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign in_range  = ({1'b0, in_data.degree} < 9'(pte_pkg::NUM_DEGREES));

  // shared horner step, wraps to 32 bits
  assign mac = acc_r * pt_r + rsp.data;

  // store port: one address, read for add or evaluate, write for add, clear on an accepted clear
  always_comb begin
    req         = '0;
    req.wr_data = rsp.data + coef_r;
    case (state_r)
      S_ADD_RD: begin
        req.rd_en = 1'b1;
        req.addr  = deg_r;
      end
      S_ADD_WR: begin
        req.wr_en = 1'b1;
        req.addr  = deg_r;
      end
      S_EVAL: begin
        req.rd_en = 1'b1;
        req.addr  = cnt_r;
      end
      S_IDLE: begin
        req.clr = accept && (in_data.func == pte_pkg::FN_CLEAR);
      end
      default: begin
        req.rd_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt.value = '0;
          case (in_data.func)
            pte_pkg::FN_ADD: begin
              if (in_range) begin
                state_nxt = S_ADD_RD;
              end else begin
                res_nxt.status = pte_pkg::ST_REJECTED;
                state_nxt      = S_PUSH;
              end
            end
            pte_pkg::FN_EVAL: begin
              cnt_nxt   = TOP_DEG;
              acc_nxt   = '0;
              state_nxt = S_EVAL;
            end
            pte_pkg::FN_CLEAR: begin
              res_nxt.status = pte_pkg::ST_CLEARED;
              state_nxt      = S_PUSH;
            end
            default: begin
              // unused code
              res_nxt.status = pte_pkg::ST_REJECTED;
              state_nxt      = S_PUSH;
            end
          endcase
        end
      end
      S_ADD_RD: begin
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        // constant term always counts as present
        res_nxt.status = (rsp.hit || deg0_r) ? pte_pkg::ST_MERGED : pte_pkg::ST_NEW;
        state_nxt      = S_PUSH;
      end
      S_EVAL: begin
        if (pend_r) begin
          acc_nxt = mac;
        end
        if (cnt_r == '0) begin
          state_nxt = S_EVAL_END;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_EVAL_END: begin
        // last coefficient arrives here
        res_nxt.value  = mac;
        res_nxt.status = pte_pkg::ST_EVALUATED;
        state_nxt      = S_PUSH;
      end
      S_PUSH: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == S_EVAL);
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    if (accept) begin
      pt_r   <= in_data.point;
      coef_r <= in_data.coefficient;
      deg_r  <= in_data.degree[pte_pkg::DEG_W-1:0];
      deg0_r <= (in_data.degree == 8'd0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_PUSH && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PUSH && slot_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `PTE_ASSERT_NXT(a_eval_start, accept && (in_data.func == pte_pkg::FN_EVAL), state_r == S_EVAL)
  `PTE_ASSERT_NXT(a_eval_walk, (state_r == S_EVAL) && (cnt_r != '0), state_r == S_EVAL)
  `PTE_ASSERT_NXT(a_eval_end, state_r == S_EVAL_END, state_r == S_PUSH)
  `PTE_ASSERT_IMP(a_wr_no_clr, req.wr_en, !req.clr && !req.rd_en)

endmodule

`default_nettype wire
